>>> rtl/core/b64c_pkg.sv
package b64c_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   localparam logic [7:0] PAD_CHAR   = 8'h3D;
   localparam logic [7:0] PLUS_CHAR  = 8'h2B;
   localparam logic [7:0] SLASH_CHAR = 8'h2F;

   // Kind of work handed from the front to the back.
   typedef enum logic [2:0] {
      CMD_ENC   = 3'b001,
      CMD_DEC   = 3'b010,
      CMD_EMPTY = 3'b100
   } cmd_op_type;

   // One group ready for output. For encode, limit is the index of the last
   // alphabet character (the rest up to four are pad). For decode, limit is
   // the index of the last byte.
   typedef struct packed {
      cmd_op_type  op;
      logic [23:0] word;
      logic [1:0]  limit;
      logic        last;
   } cmd_type;

   // Returns {is_alphabet, sextet}.
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [6:0] r;
      r = 7'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = {1'b1, 6'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r = {1'b1, 6'(c - 8'd71)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 6'(c + 8'd4)};
      end else if (c == PLUS_CHAR) begin
         r = {1'b1, 6'd62};
      end else if (c == SLASH_CHAR) begin
         r = {1'b1, 6'd63};
      end
      return r;
   endfunction

   function automatic logic [7:0] alpha_char(input logic [5:0] s);
      logic [7:0] r;
      if (s < 6'd26) begin
         r = 8'h41 + {2'b00, s};
      end else if (s < 6'd52) begin
         r = {2'b00, s} + 8'd71;
      end else if (s < 6'd62) begin
         r = {2'b00, s} - 8'd4;
      end else if (s == 6'd62) begin
         r = PLUS_CHAR;
      end else begin
         r = SLASH_CHAR;
      end
      return r;
   endfunction

endpackage

>>> rtl/core/b64c_front.sv
module b64c_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_wdata,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tlast,
   input  logic              q_full,
   output logic              q_push,
   output b64c_pkg::cmd_type q_cmd
);
   import b64c_pkg::*;

   logic        mode_ff, mode_in;
   logic [17:0] group_buffer_ff, group_buffer_in;
   logic [1:0]  group_count_ff, group_count_in;
   logic        stopped_ff, stopped_in;

   logic        accept;
   logic [1:0]  enc_cnt;
   logic [6:0]  sx;
   logic [17:0] hold_buf;
   logic [1:0]  hold_cnt;
   logic        emitted;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;
   assign sx         = sextet_of(req_tdata);

   always_comb begin
      mode_in         = mode_ff;
      group_buffer_in = group_buffer_ff;
      group_count_in  = group_count_ff;
      stopped_in      = stopped_ff;
      q_push          = 1'b0;
      q_cmd.op        = CMD_ENC;
      q_cmd.word      = 24'd0;
      q_cmd.limit     = 2'd0;
      q_cmd.last      = req_tlast;
      enc_cnt         = group_count_ff + 2'd1;
      hold_buf        = group_buffer_ff;
      hold_cnt        = group_count_ff;
      emitted         = 1'b0;

      if (accept) begin
         if (mode_ff == MODE_ENCODE) begin
            if (enc_cnt == 2'd3 || req_tlast) begin
               q_push      = 1'b1;
               q_cmd.op    = CMD_ENC;
               q_cmd.limit = enc_cnt;
               case (enc_cnt)
                  2'd1:    q_cmd.word = {req_tdata, 16'd0};
                  2'd2:    q_cmd.word = {group_buffer_ff[7:0], req_tdata, 8'd0};
                  default: q_cmd.word = {group_buffer_ff[15:0], req_tdata};
               endcase
               group_buffer_in = 18'd0;
               group_count_in  = 2'd0;
            end else begin
               group_buffer_in = {2'b00, group_buffer_ff[7:0], req_tdata};
               group_count_in  = enc_cnt;
            end
         end else begin
            if (!stopped_ff) begin
               if (!sx[6]) begin
                  stopped_in = 1'b1;
               end else if (group_count_ff == 2'd3) begin
                  q_push      = 1'b1;
                  q_cmd.op    = CMD_DEC;
                  q_cmd.word  = {group_buffer_ff, sx[5:0]};
                  q_cmd.limit = 2'd2;
                  emitted     = 1'b1;
                  hold_buf    = 18'd0;
                  hold_cnt    = 2'd0;
               end else begin
                  hold_buf = {group_buffer_ff[11:0], sx[5:0]};
                  hold_cnt = group_count_ff + 2'd1;
               end
            end
            group_buffer_in = hold_buf;
            group_count_in  = hold_cnt;
            if (req_tlast) begin
               if (!emitted) begin
                  q_push = 1'b1;
                  if (hold_cnt == 2'd3) begin
                     q_cmd.op    = CMD_DEC;
                     q_cmd.word  = {hold_buf, 6'd0};
                     q_cmd.limit = 2'd1;
                  end else if (hold_cnt == 2'd2) begin
                     q_cmd.op    = CMD_DEC;
                     q_cmd.word  = {hold_buf[11:0], 12'd0};
                     q_cmd.limit = 2'd0;
                  end else begin
                     q_cmd.op = CMD_EMPTY;
                  end
               end
               group_buffer_in = 18'd0;
               group_count_in  = 2'd0;
               stopped_in      = 1'b0;
            end
         end
      end

      // A mode change abandons any message in progress.
      if (csr_we) begin
         mode_in         = csr_wdata;
         group_buffer_in = 18'd0;
         group_count_in  = 2'd0;
         stopped_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_ENCODE;
         group_buffer_ff <= 18'd0;
         group_count_ff  <= 2'd0;
         stopped_ff      <= 1'b0;
      end else begin
         mode_ff         <= mode_in;
         group_buffer_ff <= group_buffer_in;
         group_count_ff  <= group_count_in;
         stopped_ff      <= stopped_in;
      end
   end

endmodule

>>> rtl/core/b64c_fifo.sv
module b64c_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64c_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output b64c_pkg::cmd_type head_cmd
);
   import b64c_pkg::*;

   cmd_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   function automatic logic [QUEUE_PTR_W-1:0] next_ptr(input logic [QUEUE_PTR_W-1:0] p);
      logic [QUEUE_PTR_W-1:0] r;
      if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/core/b64c_back.sv
module b64c_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  b64c_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tuser,
   output logic              rsp_tlast
);
   import b64c_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_flag_ff, rsp_flag_in;
   logic       rsp_last_ff, rsp_last_in;

   logic       advance;
   logic       fire;
   logic       done;
   logic [5:0] sextet;
   logic [7:0] dec_byte;

   assign advance = !rsp_valid_ff || rsp_tready;
   assign fire    = advance && q_valid;

   always_comb begin
      case (idx_ff)
         2'd0:    sextet = q_cmd.word[23:18];
         2'd1:    sextet = q_cmd.word[17:12];
         2'd2:    sextet = q_cmd.word[11:6];
         default: sextet = q_cmd.word[5:0];
      endcase
      case (idx_ff)
         2'd0:    dec_byte = q_cmd.word[23:16];
         2'd1:    dec_byte = q_cmd.word[15:8];
         default: dec_byte = q_cmd.word[7:0];
      endcase
   end

   always_comb begin
      rsp_byte_in = 8'd0;
      rsp_flag_in = 1'b1;
      done        = 1'b1;
      unique case (q_cmd.op)
         CMD_ENC: begin
            rsp_byte_in = (idx_ff <= q_cmd.limit) ? alpha_char(sextet) : PAD_CHAR;
            done        = (idx_ff == 2'd3);
         end
         CMD_DEC: begin
            rsp_byte_in = dec_byte;
            done        = (idx_ff == q_cmd.limit);
         end
         default: begin
            rsp_flag_in = 1'b0;
         end
      endcase
      rsp_last_in  = q_cmd.last && done;
      q_pop        = fire && done;
      idx_in       = fire ? (done ? 2'd0 : idx_ff + 2'd1) : idx_ff;
      rsp_valid_in = advance ? q_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_flag_ff <= rsp_flag_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_flag_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> rtl/core/base64_stream_codec.sv
// Channel   | Direction | Payload
// ----------+-----------+-------------------------------------------------------------
// req_      | in        | tdata[7:0] data_byte, tlast last
// rsp_      | out       | tdata[7:0] out_byte, tuser[0] out_valid, tlast out_last
// csr_      | in        | we with wdata[0] mode (0 encode, 1 decode)
//
// The front accepts one input transaction per cycle whenever its group queue has room,
// and the back sends one result transaction per cycle from its output register while
// the receiver is ready and the queue holds a command. The sustained encode rate is set
// by the back's serializer: encoding gives four results for three input bytes.
// A group's first result goes through the queue and then the back's output register.
// Reset is synchronous and active high; it selects encode mode and empties the block.
// Either side may stall freely; the two-entry queue decouples them.
module base64_stream_codec (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_wdata,     // mode
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,     // [7:0] data_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,     // [7:0] out_byte
   output logic       rsp_tuser,     // [0] out_valid
   output logic       rsp_tlast
);
   import b64c_pkg::*;

   // The front classifies each byte against the running group and, when a group
   // completes or the message ends, hands one command to the queue.
   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_valid;
   cmd_type push_cmd;
   cmd_type head_cmd;

   b64c_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   b64c_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (head_cmd)
   );

   // The back walks through the characters or bytes of the head command.
   b64c_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (head_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // The front never writes into a full queue.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("command pushed into a full queue");

   // The back only retires a command that is present.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("command popped from an empty queue");

   // An empty end marker always closes the message and carries a zero byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tlast && rsp_tdata == 8'd0))
      else $error("empty end marker without last or with data");

   // Once a result is presented it stays until taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import b64c_pkg::*;

   // Clock and reset timing.
   localparam int CLK_HIGH     = 6;
   localparam int CLK_LOW      = 6;
   localparam int RESET_CYCLES = 4;

   // Idling on both sides is drawn per transaction, from none up to MAX_GAP.
   localparam int MAX_GAP    = 7;
   // The receiver's long hold-off, counted in cycles by the receiver itself.
   localparam int LONG_HOLD  = 80;
   // Cycles that pass after the last owed result before the block is treated as idle.
   // The first result of a group goes through the queue and then the back's output register,
   // so this leaves ample margin.
   localparam int DRAIN_TAIL = 8;

   // Random part: PHASES phases of at least PHASE_ITEMS input transactions each.
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 30;
   // Phase in which the receiver holds off while the sender streams without gaps.
   localparam int PRESSURE_PHASE = 4;
   // Length of the gapless message sent into the stalled block.
   localparam int PRESSURE_LEN   = 24;

   // Generous bound on the whole run; the slowest correct run needs well under a tenth.
   localparam int TIMEOUT_NS = 2000000;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   logic       csr_wdata;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic       rsp_tuser;
   logic       rsp_tlast;

   // One result transaction as the block should send it.
   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       last;
   } codec_out_type;

   // The scoreboard keeps its own copy of the codec state and the mode register. Every
   // accepted input transaction is run through the same base64 rules, and the results that
   // it must cause are queued in order; each result transaction is checked against the
   // oldest of them.
   class codec_scoreboard;
      logic          mode;
      logic [23:0]   group;
      int unsigned   count;
      bit            stopped;
      codec_out_type owed_outputs[$];
      int unsigned   errors;
      int unsigned   inputs;
      int unsigned   outputs;
      int unsigned   empty_ends;

      function new();
         mode       = MODE_ENCODE;
         errors     = 0;
         inputs     = 0;
         outputs    = 0;
         empty_ends = 0;
         clear_group();
      endfunction

      function void clear_group();
         group   = '0;
         count   = 0;
         stopped = 1'b0;
      endfunction

      // A mode write abandons whatever message is in progress.
      function void set_mode(input logic m);
         mode = m;
         clear_group();
      endfunction

      // Alphabet character for a six-bit value.
      function logic [7:0] char_of(input logic [5:0] s);
         int v;
         v = s;
         if (v < 26) begin
            v = v + "A";
         end else if (v < 52) begin
            v = v - 26 + "a";
         end else if (v < 62) begin
            v = v - 52 + "0";
         end else if (v == 62) begin
            v = PLUS_CHAR;
         end else begin
            v = SLASH_CHAR;
         end
         return v[7:0];
      endfunction

      // Six-bit value of an alphabet character, or -1 for anything else.
      function int value_of(input logic [7:0] c);
         int v;
         v = c;
         if (c >= "A" && c <= "Z") begin
            return v - "A";
         end else if (c >= "a" && c <= "z") begin
            return v - "a" + 26;
         end else if (c >= "0" && c <= "9") begin
            return v - "0" + 52;
         end else if (c == PLUS_CHAR) begin
            return 62;
         end else if (c == SLASH_CHAR) begin
            return 63;
         end
         return -1;
      endfunction

      function void owe(input logic [7:0] d, input logic v, input logic l);
         codec_out_type item;
         item.data  = d;
         item.valid = v;
         item.last  = l;
         owed_outputs.push_back(item);
      endfunction

      function void take_encode(input logic [7:0] d, input logic lst);
         int unsigned cnt;
         logic [23:0] word;
         logic [23:0] aligned;
         int          k;
         cnt  = count + 1;
         word = {group[15:0], d};
         if (cnt == 3 || lst) begin
            // A group of cnt bytes gives cnt + 1 characters, and pad fills up to four.
            aligned = word << (8 * (3 - cnt));
            for (k = 0; k < 4; k++) begin
               if (k <= cnt) begin
                  owe(char_of(aligned[23 - 6 * k -: 6]), 1'b1, lst && k == 3);
               end else begin
                  owe(PAD_CHAR, 1'b1, lst && k == 3);
               end
            end
            group = '0;
            count = 0;
         end else begin
            group = word;
            count = cnt;
         end
      endfunction

      function void take_decode(input logic [7:0] c, input logic lst);
         int          v;
         int          k;
         int          nbytes;
         logic [23:0] word;
         logic [23:0] aligned;
         bit          flushed;
         flushed = 1'b0;
         if (!stopped) begin
            v = value_of(c);
            if (v < 0) begin
               // A pad or a foreign character ends decoding and adds nothing.
               stopped = 1'b1;
            end else begin
               word = {group[17:0], v[5:0]};
               if (count == 3) begin
                  owe(word[23:16], 1'b1, 1'b0);
                  owe(word[15:8], 1'b1, 1'b0);
                  owe(word[7:0], 1'b1, lst);
                  flushed = 1'b1;
                  group   = '0;
                  count   = 0;
               end else begin
                  group = word;
                  count = count + 1;
               end
            end
         end
         if (lst) begin
            if (!flushed) begin
               if (count >= 2) begin
                  aligned = group << (6 * (4 - count));
                  nbytes  = count - 1;
                  for (k = 0; k < nbytes; k++) begin
                     owe(aligned[23 - 8 * k -: 8], 1'b1, k + 1 == nbytes);
                  end
               end else begin
                  // Nothing left to give: a lone end marker closes the message.
                  owe(8'h00, 1'b0, 1'b1);
               end
            end
            clear_group();
         end
      endfunction

      function void take_input(input logic [7:0] d, input logic lst);
         inputs++;
         if (mode == MODE_ENCODE) begin
            take_encode(d, lst);
         end else begin
            take_decode(d, lst);
         end
      endfunction

      function void check_output(input logic [7:0] d, input logic v, input logic l);
         codec_out_type want;
         outputs++;
         if (!v) begin
            empty_ends++;
         end
         if (owed_outputs.size() == 0) begin
            errors++;
            $error("result transaction with nothing owed: out_byte %h out_valid %b out_last %b",
                   d, v, l);
            return;
         end
         want = owed_outputs.pop_front();
         if (d !== want.data) begin
            errors++;
            $error("out_byte mismatch: expected %h, actual %h", want.data, d);
         end
         if (v !== want.valid) begin
            errors++;
            $error("out_valid mismatch: expected %b, actual %b", want.valid, v);
         end
         if (l !== want.last) begin
            errors++;
            $error("out_last mismatch: expected %b, actual %b", want.last, l);
         end
      endfunction
   endclass

   codec_scoreboard board;

   // Flags shared between the stimulus process and the receiver process.
   bit tx_calm  = 1'b0;   // Sender offers every transaction without a gap.
   bit rx_calm  = 1'b0;   // Receiver is ready for every transaction without a stall.
   bit hold_rsp = 1'b0;   // Receiver should hold off for LONG_HOLD cycles.

   // Bytes of the message under construction.
   logic [7:0] msg_q[$];

   int unsigned enc_msgs   = 0;
   int unsigned dec_msgs   = 0;
   int unsigned mode_writes = 0;

   // The codec under test. The input channel carries data_byte in tdata[7:0] and last in
   // tlast; the result channel carries out_byte in tdata[7:0], out_valid in tuser[0] and
   // out_last in tlast. The one register, mode, sits in csr_wdata.
   base64_stream_codec uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #CLK_LOW clock = 1'b1;
      #CLK_HIGH clock = 1'b0;
   end

   // Offers one input transaction. The task is entered and left at a falling edge, where
   // all inputs change; acceptance is seen at the rising edge. When no gap is drawn the
   // valid stays high, so it never gets two assignments in one time step.
   task automatic send_item(input logic [7:0] data, input logic lst);
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.take_input(data, lst);
      @(negedge clock);
   endtask

   // Stops offering input and waits until every owed result has arrived, then lets the
   // block settle. The overall timeout guards against a hang.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.owed_outputs.size() != 0) @(negedge clock);
      repeat (DRAIN_TAIL) @(negedge clock);
   endtask

   // Writes the mode register while the block is idle.
   task automatic write_mode(input logic m);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= m;
      @(negedge clock);
      csr_we <= 1'b0;
      board.set_mode(m);
      mode_writes++;
   endtask

   // Sends the message built in msg_q, with tlast on its final byte when end_msg is set.
   task automatic send_msg_q(input bit end_msg);
      int i;
      for (i = 0; i < msg_q.size(); i++) begin
         send_item(msg_q[i], end_msg && i == msg_q.size() - 1);
      end
      if (end_msg) begin
         if (board.mode == MODE_ENCODE) begin
            enc_msgs++;
         end else begin
            dec_msgs++;
         end
      end
   endtask

   task automatic send_text(input string s, input bit end_msg);
      int i;
      msg_q.delete();
      for (i = 0; i < s.len(); i++) begin
         msg_q.push_back(s[i]);
      end
      send_msg_q(end_msg);
   endtask

   // Raw bytes for the encoder. Most messages are short; a few are longer. A nonzero
   // len_fixed forces the length.
   task automatic send_encode_msg(input int len_fixed, input bit end_msg);
      int len;
      int i;
      if (len_fixed > 0) begin
         len = len_fixed;
      end else if ($urandom_range(0, 7) == 0) begin
         len = $urandom_range(13, 30);
      end else begin
         len = $urandom_range(1, 12);
      end
      msg_q.delete();
      for (i = 0; i < len; i++) begin
         msg_q.push_back(8'($urandom_range(0, 255)));
      end
      send_msg_q(end_msg);
   endtask

   // Text for the decoder. Most messages are proper base64 with pad; the rest carry trailing
   // junk after the pad, a stray byte at a random place, or are pure noise.
   task automatic send_decode_msg(input bit end_msg);
      int len;
      int kind;
      int pads;
      int i;
      len  = $urandom_range(1, 12);
      kind = $urandom_range(0, 9);
      msg_q.delete();
      for (i = 0; i < len; i++) begin
         msg_q.push_back(board.char_of(6'($urandom_range(0, 63))));
      end
      if (kind <= 6) begin
         pads = (4 - len % 4) % 4;
         for (i = 0; i < pads; i++) begin
            msg_q.push_back(PAD_CHAR);
         end
         if (kind == 6) begin
            for (i = $urandom_range(1, 3); i > 0; i--) begin
               msg_q.push_back(8'($urandom_range(0, 255)));
            end
         end
      end else if (kind == 7) begin
         msg_q[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
      end else begin
         for (i = 0; i < len; i++) begin
            msg_q[i] = 8'($urandom_range(0, 255));
         end
      end
      send_msg_q(end_msg);
   endtask

   task automatic send_random_msg(input bit end_msg);
      if (board.mode == MODE_ENCODE) begin
         send_encode_msg(0, end_msg);
      end else begin
         send_decode_msg(end_msg);
      end
   endtask

   // Receiver. It draws a stall before every result transaction and, when asked, holds off
   // for a long stretch that it counts itself, while the sender keeps offering input.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_rsp = 1'b0;
         end
         stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         board.check_output(rsp_tdata, rsp_tuser, rsp_tlast);
         @(negedge clock);
      end
   end

   // Stimulus.
   initial begin
      int phase;
      int phase_start;
      board      = new();
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_wdata  = MODE_ENCODE;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed encoding: byte extremes in a full group, then one-byte and two-byte
      // partial groups that must be padded.
      write_mode(MODE_ENCODE);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h80, 1'b0);
      send_item(8'hFF, 1'b1);
      send_item(8'hFB, 1'b0);
      send_item(8'hFF, 1'b1);
      send_item(8'h00, 1'b1);
      enc_msgs += 3;

      // Directed decoding. The first message covers the ends of every alphabet range and
      // a full group that carries the last flag.
      write_mode(MODE_DECODE);
      send_text("+/z0AZa9", 1'b1);
      // A pad that carries the last flag still flushes the three pending characters.
      send_text("QUI=", 1'b1);
      // A single pending character gives no bytes, so only an end marker comes back.
      send_text("Q", 1'b1);
      // A character above the ASCII range stops decoding; what follows is ignored.
      send_text("AB", 1'b0);
      send_item(8'hC3, 1'b0);
      send_text("D", 1'b1);
      // This message is abandoned by the mode write that follows.
      send_text("TW", 1'b0);
      wait_drained();

      // Random phases alternate the mode, starting from encode.
      for (phase = 0; phase < PHASES; phase++) begin
         write_mode(phase % 2 == 0 ? MODE_ENCODE : MODE_DECODE);
         tx_calm = (phase == 2 || phase == 7);
         rx_calm = (phase == 2 || phase == 7);
         phase_start = board.inputs;
         if (phase == PRESSURE_PHASE) begin
            // The receiver stops for a long stretch while the sender streams a long
            // message without gaps, so the block fills up and stalls its input. After
            // that the sender pauses until everything has come back.
            hold_rsp = 1'b1;
            tx_calm  = 1'b1;
            send_encode_msg(PRESSURE_LEN, 1'b1);
            tx_calm  = 1'b0;
            wait_drained();
         end
         while (board.inputs - phase_start < PHASE_ITEMS) begin
            send_random_msg(1'b1);
            if ($urandom_range(0, 9) == 0) begin
               wait_drained();
            end
         end
         // Sometimes a phase ends inside a message, which the next mode write abandons.
         if ($urandom_range(0, 3) == 0) begin
            send_random_msg(1'b0);
         end
      end
      tx_calm = 1'b0;
      rx_calm = 1'b0;
      wait_drained();

      $display("Run covered %0d input and %0d result transactions, %0d of them end markers.",
               board.inputs, board.outputs, board.empty_ends);
      $display("Messages closed: %0d encoded, %0d decoded; mode register written %0d times.",
               enc_msgs, dec_msgs, mode_writes);
      if (board.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog for a block that hangs.
   initial begin
      #TIMEOUT_NS;
      $display("Timeout with %0d results still owed.", board.owed_outputs.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
